>>> sv/nesting_aware_field_splitter_assert.svh
// Assertion macros shared by the splitter modules.
// Each expects clk and arst_n in scope.
`ifndef NESTING_AWARE_FIELD_SPLITTER_ASSERT_SVH
`define NESTING_AWARE_FIELD_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define NAFS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`define NAFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NAFS_ASSERT_NEVER(lbl, cond, msg)

`define NAFS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/nafs_pkg.sv
package nafs_pkg;

	// characters with fixed meaning
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	// nesting stack codes
	localparam logic [1:0] CODE_PAREN = 2'd0;
	localparam logic [1:0] CODE_BRACK = 2'd1;
	localparam logic [1:0] CODE_BRACE = 2'd2;
	localparam logic [1:0] CODE_DQUOTE = 2'd3;

	// register map, selected by paddr[2]
	localparam logic REG_SPLIT_CHAR = 1'b0;
	localparam logic REG_MAX_FIELDS = 1'b1;

	localparam logic [7:0]  SPLIT_CHAR_RST = 8'd44;
	localparam logic [15:0] MAX_FIELDS_RST = 16'd0;

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_CW    = 3;

	typedef struct packed {
		logic        ovf;
		logic        last;
		logic [15:0] len;
		logic [15:0] start;
	} res_t;

	typedef struct packed {
		logic       clear;
		logic       push;
		logic       pop;
		logic [1:0] code;
	} stk_op_t;

	typedef struct packed {
		logic       empty;
		logic       full;
		logic [1:0] top;
	} stk_stat_t;

endpackage

>>> sv/nafs_stack.sv
`include "nesting_aware_field_splitter_assert.svh"

module nafs_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nafs_pkg::stk_op_t   op,
	output nafs_pkg::stk_stat_t stat
);
	import nafs_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [1:0]    mem [STACK_DEPTH];
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_nx;
	logic [DW-1:0] ra_full;
	logic [AW-1:0] ra;
	logic [1:0]    top_q;
	logic [1:0]    below_q;
	logic          empty;
	logic          full;
	logic          do_push;

	assign empty   = (depth_q == '0);
	assign full    = (depth_q == DW'(STACK_DEPTH));
	assign do_push = op.push && !full;

	always_comb begin
		priority if (op.clear) begin
			depth_nx = '0;
		end else if (do_push) begin
			depth_nx = depth_q + DW'(1);
		end else if (op.pop) begin
			depth_nx = depth_q - DW'(1);
		end else begin
			depth_nx = depth_q;
		end
	end

	// prefetch the entry under the next top; it never aliases the push slot
	assign ra_full = depth_nx - DW'(2);
	assign ra      = (depth_nx >= DW'(2)) ? ra_full[AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && !op.clear) begin
			mem[depth_q[AW-1:0]] <= op.code;
		end
		below_q <= mem[ra];
		if (do_push) begin
			top_q <= op.code;
		end else if (op.pop) begin
			top_q <= below_q;
		end
	end

	assign stat.empty = empty;
	assign stat.full  = full;
	assign stat.top   = top_q;

	`NAFS_ASSERT_NEVER(a_pop_empty, op.pop && empty, "pop on empty stack")
	`NAFS_ASSERT_NEXT(a_push_nonempty, do_push && !op.clear, !stat.empty,
		"stack empty after push")
	`NAFS_ASSERT_NEXT(a_push_top, do_push && !op.clear, stat.top == $past(op.code),
		"top differs from pushed code")

endmodule

>>> sv/nafs_outq.sv
`include "nesting_aware_field_splitter_assert.svh"

module nafs_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     wr_cnt,
	input  nafs_pkg::res_t wr_d0,
	input  nafs_pkg::res_t wr_d1,
	output logic           room2,
	output logic           rd_valid,
	input  logic           rd_ready,
	output nafs_pkg::res_t rd_d
);
	import nafs_pkg::*;

	res_t             q_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_CW-1:0] count_q;
	logic             rd_fire;

	assign rd_valid = (count_q != '0);
	assign rd_fire  = rd_valid && rd_ready;
	assign room2    = (count_q <= OQ_CW'(OQ_DEPTH - 2));
	assign rd_d     = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + OQ_AW'(wr_cnt);
			rp_q    <= rp_q + OQ_AW'(rd_fire);
			count_q <= count_q + OQ_CW'(wr_cnt) - OQ_CW'(rd_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			q_q[wp_q] <= wr_d0;
		end
		if (wr_cnt == 2'd2) begin
			q_q[wp_q + OQ_AW'(1)] <= wr_d1;
		end
	end

	`NAFS_ASSERT_NEVER(a_count_range, count_q > OQ_CW'(OQ_DEPTH), "queue count out of range")
	`NAFS_ASSERT_NEVER(a_no_overrun, OQ_CW'(wr_cnt) > OQ_CW'(OQ_DEPTH) - count_q,
		"write beyond free space")
	`NAFS_ASSERT_NEXT(a_wr_visible, wr_cnt != 2'd0, rd_valid, "written result not visible")

endmodule

>>> sv/nesting_aware_field_splitter.sv
// A result is written into the result queue when its input request is accepted and is offered on m_tvalid from there.
// Throughput: one input request per cycle while s_tready is high; an item may produce up to two results.
// s_tready drops while the four-entry result queue holds more than two results.
// Nesting stack lives in a synchronous RAM with a prefetched entry under a top register.
// Reset clears all control state and loads the register defaults; no clearing pass needed.
// State for a string is cleared after each request marked tlast.
module nesting_aware_field_splitter #(
	parameter int STACK_DEPTH = 16,
	parameter int POS_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic        s_tuser,  // [0] has_byte
	input  logic        s_tlast,  // end_of_string
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] field_start, [31:16] field_length
	output logic        m_tuser,  // [0] overflow
	output logic        m_tlast   // last_field
);
	import nafs_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [7:0]          split_q;
	logic [15:0]         maxf_q;
	logic [POS_BITS-1:0] bpos_q;
	logic [POS_BITS-1:0] fbeg_q;
	logic [15:0]         fdone_q;
	logic                lim_q;
	logic                sq_q;
	logic                ovf_q;

	logic                acc;
	logic                has;
	logic                eos;
	logic [7:0]          ch;
	logic                sat;
	logic                act;
	logic                is_sq;
	logic                split_cond;
	logic                lim_hit;
	logic                split_out;
	logic                base;
	logic                is_open;
	logic                is_dq;
	logic                close_match;
	logic [1:0]          open_code;
	logic                push;
	logic                pop;
	logic                ovf_nx;
	logic [POS_BITS-1:0] bpos_nx;
	logic [POS_BITS-1:0] fbeg_nx;
	logic [POS_BITS-1:0] len0;
	logic [POS_BITS-1:0] len1;
	logic [31:0]         start0_w;
	logic [31:0]         start1_w;
	logic [31:0]         len0_w;
	logic [31:0]         len1_w;
	logic                last_out;
	logic [1:0]          wr_cnt;
	res_t                r_split;
	res_t                r_last;
	res_t                wr_d0;
	res_t                rd_d;
	logic                room2;
	stk_op_t             sop;
	stk_stat_t           sstat;
	logic                cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= SPLIT_CHAR_RST;
			maxf_q  <= MAX_FIELDS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SPLIT_CHAR: split_q <= pwdata[7:0];
				REG_MAX_FIELDS: maxf_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SPLIT_CHAR: prdata = {24'd0, split_q};
			REG_MAX_FIELDS: prdata = {16'd0, maxf_q};
			default:        prdata = '0;
		endcase
	end

	// byte scan
	assign s_tready = room2;
	assign acc      = s_tvalid && s_tready;
	assign has      = s_tuser;
	assign eos      = s_tlast;
	assign ch       = s_tdata;

	assign sat     = (bpos_q == POS_MAX);
	assign bpos_nx = (has && !sat) ? bpos_q + POS_BITS'(1) : bpos_q;

	assign act        = has && !lim_q;
	assign is_sq      = (ch == CH_SQUOTE);
	assign split_cond = (ch == split_q) && sstat.empty && !sq_q;
	assign lim_hit    = (maxf_q != 16'd0) && ({1'b0, fdone_q} + 17'd1 == {1'b0, maxf_q});
	assign split_out  = act && !is_sq && split_cond && !lim_hit;
	assign base       = act && !is_sq && !split_cond;

	assign is_open = (ch == CH_LPAREN) || (ch == CH_LBRACK) || (ch == CH_LBRACE);
	assign is_dq   = (ch == CH_DQUOTE);

	always_comb begin
		priority if (ch == CH_LPAREN) begin
			open_code = CODE_PAREN;
		end else if (ch == CH_LBRACK) begin
			open_code = CODE_BRACK;
		end else if (ch == CH_LBRACE) begin
			open_code = CODE_BRACE;
		end else begin
			open_code = CODE_DQUOTE;
		end
	end

	assign close_match = ((ch == CH_RPAREN) && (sstat.top == CODE_PAREN))
		|| ((ch == CH_RBRACK) && (sstat.top == CODE_BRACK))
		|| ((ch == CH_RBRACE) && (sstat.top == CODE_BRACE))
		|| (is_dq && (sstat.top == CODE_DQUOTE));

	assign push = base && (is_open || (is_dq && (sstat.empty || sstat.top != CODE_DQUOTE)));
	assign pop  = base && !push && !sstat.empty && close_match;

	assign ovf_nx  = ovf_q || (has && sat) || (push && sstat.full);
	assign fbeg_nx = split_out ? (sat ? POS_MAX : bpos_q + POS_BITS'(1)) : fbeg_q;

	assign len0     = bpos_q - fbeg_q;
	assign len1     = bpos_nx - fbeg_nx;
	assign start0_w = 32'(fbeg_q);
	assign start1_w = 32'(fbeg_nx);
	assign len0_w   = 32'(len0);
	assign len1_w   = 32'(len1);
	assign last_out = eos && (bpos_nx != '0);

	assign r_split = '{ovf: ovf_nx, last: 1'b0, len: len0_w[15:0], start: start0_w[15:0]};
	assign r_last  = '{ovf: ovf_nx, last: 1'b1, len: len1_w[15:0], start: start1_w[15:0]};
	assign wr_d0   = split_out ? r_split : r_last;
	assign wr_cnt  = acc ? (2'(split_out) + 2'(last_out)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q  <= '0;
			fbeg_q  <= '0;
			fdone_q <= '0;
			lim_q   <= 1'b0;
			sq_q    <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (eos) begin
				bpos_q  <= '0;
				fbeg_q  <= '0;
				fdone_q <= '0;
				lim_q   <= 1'b0;
				sq_q    <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				bpos_q <= bpos_nx;
				fbeg_q <= fbeg_nx;
				ovf_q  <= ovf_nx;
				if (split_out && fdone_q != 16'hFFFF) begin
					fdone_q <= fdone_q + 16'd1;
				end
				if (act && !is_sq && split_cond && lim_hit) begin
					lim_q <= 1'b1;
				end
				if (act && is_sq) begin
					sq_q <= !sq_q;
				end
			end
		end
	end

	assign sop.clear = acc && eos;
	assign sop.push  = acc && push;
	assign sop.pop   = acc && pop;
	assign sop.code  = open_code;

	nafs_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (sop),
		.stat   (sstat)
	);

	nafs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (wr_cnt),
		.wr_d0    (wr_d0),
		.wr_d1    (r_last),
		.room2    (room2),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_d     (rd_d)
	);

	assign m_tdata = {rd_d.len, rd_d.start};
	assign m_tuser = rd_d.ovf;
	assign m_tlast = rd_d.last;

endmodule
